/* rtl/wavhp_pkg.sv */
// Package for the WAV header parser: result type, magic tags, status and error codes,
// and the expected 16-bit stereo 44100 Hz PCM format body. No dependencies.
package wavhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // smallest RIFF length that can hold WAVE, a fmt chunk, a data header and one data byte
    localparam logic [31:0] RIFF_MIN_LEN = 32'(4 + 8 + 16 + 8 + 1);
    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;

    localparam logic [1:0] STATUS_BUSY  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_RIFF    = 3'd1;
    localparam logic [2:0] ERR_RIFF_SHORT  = 3'd2;
    localparam logic [2:0] ERR_BAD_WAVE    = 3'd3;
    localparam logic [2:0] ERR_OVERRUN     = 3'd4;
    localparam logic [2:0] ERR_FMT_SMALL   = 3'd5;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd6;
    localparam logic [2:0] ERR_EARLY_END   = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  error_code;
        logic [32:0] data_offset;
        logic [31:0] data_length;
    } t_result;

    // expected fmt body: PCM, 2 channels, 44100 Hz, 176400 B/s, align 4, 16 bits
    function automatic logic [7:0] fmt_expect(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h01;
            4'd2:    val = 8'h02;
            4'd4:    val = 8'h44;
            4'd5:    val = 8'hac;
            4'd8:    val = 8'h10;
            4'd9:    val = 8'hb1;
            4'd10:   val = 8'h02;
            4'd12:   val = 8'h04;
            4'd14:   val = 8'h10;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

/* rtl/wavhp_if.sv */
// Valid/ready channel interfaces for the WAV header parser.
// Depends on nothing.
interface wavhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface wavhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  error_code;
    logic [32:0] data_offset;
    logic [31:0] data_length;

    modport source (output valid, output status, output error_code, output data_offset,
                    output data_length, input ready);
    modport sink   (input valid, input status, input error_code, input data_offset,
                    input data_length, output ready);
endinterface

/* rtl/wavhp_core.sv */
// Parse state and per-byte next-state logic of the WAV header parser.
// Depends on wavhp_pkg.
module wavhp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [7:0]         i_data_byte,
    input  logic               i_stream_end,
    output wavhp_pkg::t_result o_result
);
    import wavhp_pkg::*;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_WAVE,
        PH_HEAD,
        PH_FMT,
        PH_SKIP,
        PH_DONE,
        PH_ERR
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_idx,      n_idx;
    logic [31:0] r_gather,   n_gather;
    logic [31:0] r_tag,      n_tag;
    logic [31:0] r_riff_len, n_riff_len;
    logic [31:0] r_rem,      n_rem;
    logic [31:0] r_clen,     n_clen;
    logic [31:0] r_skip,     n_skip;
    logic        r_fmt_seen, n_fmt_seen;
    logic [2:0]  r_err,      n_err;
    logic [32:0] r_offset,   n_offset;

    logic        go_header;
    logic        active;
    logic [3:0]  idx_inc;
    logic [31:0] gather_in;
    logic [31:0] tag_in;
    logic [31:0] rem_hdr;
    logic [31:0] fmt_extra;

    assign active    = (r_phase != PH_DONE) && (r_phase != PH_ERR);
    assign idx_inc   = r_idx + 4'd1;
    assign gather_in = {i_data_byte, r_gather[31:8]};
    assign tag_in    = {r_tag[23:0], i_data_byte};
    assign rem_hdr   = r_rem - CHUNK_HDR_LEN;
    assign fmt_extra = r_clen - FMT_BODY_LEN;

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_gather   = r_gather;
        n_tag      = r_tag;
        n_riff_len = r_riff_len;
        n_rem      = r_rem;
        n_clen     = r_clen;
        n_skip     = r_skip;
        n_fmt_seen = r_fmt_seen;
        n_err      = r_err;
        n_offset   = r_offset;
        go_header  = 1'b0;

        if (i_take && active) begin
            if (i_stream_end) begin
                n_phase = PH_ERR;
                n_err   = ERR_EARLY_END;
            end else begin
                case (r_phase)
                    PH_RIFF: begin
                        n_idx = idx_inc;
                        if (r_idx < 4'd4) begin
                            n_tag = tag_in;
                        end else begin
                            n_gather = gather_in;
                        end
                        if (idx_inc == 4'd8) begin
                            if (n_tag != TAG_RIFF) begin
                                n_phase = PH_ERR;
                                n_err   = ERR_BAD_RIFF;
                            end else if (n_gather < RIFF_MIN_LEN) begin
                                n_phase = PH_ERR;
                                n_err   = ERR_RIFF_SHORT;
                            end else begin
                                n_riff_len = n_gather;
                                n_phase    = PH_WAVE;
                                n_idx      = 4'd0;
                                n_tag      = 32'd0;
                            end
                        end
                    end
                    PH_WAVE: begin
                        n_tag = tag_in;
                        n_idx = idx_inc;
                        if (idx_inc == 4'd4) begin
                            n_rem = r_riff_len - 32'd4;
                            if (tag_in != TAG_WAVE) begin
                                n_phase = PH_ERR;
                                n_err   = ERR_BAD_WAVE;
                            end else begin
                                go_header = 1'b1;
                            end
                        end
                    end
                    PH_HEAD: begin
                        n_idx = idx_inc;
                        if (r_idx < 4'd4) begin
                            n_tag = tag_in;
                        end else begin
                            n_gather = gather_in;
                        end
                        if (idx_inc == 4'd8) begin
                            n_rem  = rem_hdr;
                            n_clen = n_gather;
                            if (rem_hdr < n_gather) begin
                                n_phase = PH_ERR;
                                n_err   = ERR_OVERRUN;
                            end else if (!r_fmt_seen && n_tag == TAG_FMT) begin
                                if (n_gather < FMT_BODY_LEN) begin
                                    n_phase = PH_ERR;
                                    n_err   = ERR_FMT_SMALL;
                                end else begin
                                    n_rem    = rem_hdr - n_gather;
                                    n_phase  = PH_FMT;
                                    n_idx    = 4'd0;
                                    n_gather = 32'd0;
                                end
                            end else if (r_fmt_seen && n_tag == TAG_DATA) begin
                                // offset = riff_len - (rem - 8) + 8
                                n_phase  = PH_DONE;
                                n_err    = ERR_NONE;
                                n_offset = {1'b0, r_riff_len} - {1'b0, r_rem} + 33'd16;
                            end else begin
                                n_rem  = rem_hdr - n_gather;
                                n_skip = n_gather;
                                if (n_gather == 32'd0) begin
                                    go_header = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                    end
                    PH_FMT: begin
                        // accumulate any mismatch against the expected body
                        n_gather = r_gather | {24'd0, i_data_byte ^ fmt_expect(r_idx)};
                        n_idx    = idx_inc;
                        if (idx_inc == 4'd0) begin
                            if (n_gather != 32'd0) begin
                                n_phase = PH_ERR;
                                n_err   = ERR_UNSUPPORTED;
                            end else begin
                                n_fmt_seen = 1'b1;
                                n_skip     = fmt_extra;
                                if (fmt_extra == 32'd0) begin
                                    go_header = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_skip = r_skip - {31'd0, (r_skip != 32'd0)};
                        if (n_skip == 32'd0) begin
                            go_header = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                // next chunk header needs room for its 8 bytes
                if (go_header) begin
                    if (n_rem < CHUNK_HDR_LEN) begin
                        n_phase = PH_ERR;
                        n_err   = ERR_OVERRUN;
                    end else begin
                        n_phase  = PH_HEAD;
                        n_idx    = 4'd0;
                        n_tag    = 32'd0;
                        n_gather = 32'd0;
                    end
                end
            end
        end
    end

    always_comb begin
        o_result = '0;
        case (n_phase)
            PH_DONE: begin
                o_result.status      = STATUS_DONE;
                o_result.error_code  = ERR_NONE;
                o_result.data_offset = n_offset;
                o_result.data_length = n_clen;
            end
            PH_ERR: begin
                o_result.status     = STATUS_ERROR;
                o_result.error_code = n_err;
            end
            default: begin
                o_result.status = STATUS_BUSY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF;
            r_idx      <= 4'd0;
            r_fmt_seen <= 1'b0;
            r_err      <= ERR_NONE;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_fmt_seen <= n_fmt_seen;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gather   <= n_gather;
        r_tag      <= n_tag;
        r_riff_len <= n_riff_len;
        r_rem      <= n_rem;
        r_clen     <= n_clen;
        r_skip     <= n_skip;
        r_offset   <= n_offset;
    end

endmodule

/* rtl/wavhp_outreg.sv */
// Result register of the WAV header parser; drives the output channel.
// Depends on wavhp_pkg and wavhp_out_if.
module wavhp_outreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  wavhp_pkg::t_result i_result,
    output logic               o_room,
    wavhp_out_if.source        o_out
);
    import wavhp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or when the held result leaves this cycle
    assign o_room = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_result.status;
    assign o_out.error_code  = r_result.error_code;
    assign o_out.data_offset = r_result.data_offset;
    assign o_out.data_length = r_result.data_length;

endmodule

/* rtl/wav_header_parser.sv */
// Top level of the WAV header parser: byte input channel, result output channel.
// Depends on wavhp_pkg, wavhp_if, wavhp_core and wavhp_outreg.
//
// Feed the WAV file one byte per input transaction, starting at the first byte of the
// "RIFF" magic; set stream_end (with no byte) to mark the end of the file. Every
// input transaction produces exactly one output transaction, in order: status 0 while
// the header is still being parsed, 1 once the "data" chunk header has been read
// (data_offset is the file offset of the first PCM byte, data_length the chunk size),
// or 2 on an error with error_code giving the cause. The block accepts only
// 16-bit stereo 44100 Hz PCM in its "fmt " chunk; chunks before "fmt " and between
// "fmt " and "data" are skipped, and any chunk that would run past the RIFF length is
// an error. Once done or in error the outcome is held and repeated for every further
// transaction until reset. Throughput is one byte per clock unless the output stalls;
// a result is output the cycle after its byte is taken. The per-byte state update in
// the core (tag/length shift, one chunk-length subtract and compare) sets that pace.
module wav_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wavhp_in_if.sink    i_in,
    wavhp_out_if.source o_out
);
    import wavhp_pkg::*;

    logic    room;
    logic    take;
    t_result result;

    // accept a byte whenever the result register can take its result
    assign i_in.ready = room;
    assign take       = i_in.valid && room;

    wavhp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_data_byte  (i_in.data_byte),
        .i_stream_end (i_in.stream_end),
        .o_result     (result)
    );

    // hold the result until the sink takes it
    wavhp_outreg u_outreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_result (result),
        .o_room   (room),
        .o_out    (o_out)
    );

endmodule
